// ===== src/salts_pkg.sv =====
package salts_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;
  localparam logic [1:0] CMD_INVAL = 2'd3;

  // fill report modes
  localparam logic [1:0] REPORT_VALID = 2'd1;
  localparam logic [1:0] REPORT_DIRTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WAYS_LOG2     = 2'd0;
  localparam logic [1:0] REG_LINE_BITS     = 2'd1;
  localparam logic [1:0] REG_CAPACITY_LOG2 = 2'd2;

  // configuration reset values
  localparam logic [1:0] WAYS_LOG2_RST     = 2'd2;
  localparam logic [3:0] LINE_BITS_RST     = 4'd6;
  localparam logic [4:0] CAPACITY_LOG2_RST = 5'd15;

  // field widths
  localparam int IN_ADDR_W = 32;
  localparam int TALLY_W   = 32;
  localparam int CFG_W     = 5;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 104;

  typedef logic [TALLY_W-1:0] tally_t;

endpackage

// ===== src/set_assoc_lru_tag_store_core.sv =====
// Tag store of a set-associative cache with least-recently-used replacement.
// All per-set state (valid, dirty, tag, line address, recency rank of every
// way) lives in one synchronous row memory of MAX_SETS rows, one row per set.
// After reset a clearing pass writes every row once, during which no item is
// taken (configuration writes are still taken). For each item the set row is
// read in the accept cycle, and in the update state that follows the row is
// looked up, modified and, unless the geometry is bad, written back while the
// result is loaded into the output register. The next item may be accepted
// while that result waits; a held-off output stalls the update state only.
module set_assoc_lru_tag_store_core #(
  parameter int MAX_WAYS   = 8,
  parameter int MAX_SETS   = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // cmd[1:0], address[33:2], report_mode[35:34], zero pad
  input  logic [salts_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // hit[0], victim_valid[1], victim_address[33:2], hit_count[65:34],
  // miss_count[97:66], bad_geometry[98], zero pad
  output logic [salts_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [salts_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int AW   = (ADDR_WIDTH < salts_pkg::IN_ADDR_W) ? ADDR_WIDTH
                                                            : salts_pkg::IN_ADDR_W;
  localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SETS_LOG_FLOOR = $clog2(MAX_SETS + 1) - 1;
  localparam int EW   = 2 + 2 * AW + RW;
  // entry layout: valid, dirty, tag, address, rank
  localparam int E_VALID = 0;
  localparam int E_DIRTY = 1;
  localparam int E_TAG   = 2;
  localparam int E_ADDR  = 2 + AW;
  localparam int E_RANK  = 2 + 2 * AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  typedef logic [MAX_WAYS-1:0][EW-1:0] row_t;

  logic [1:0] state;
  logic [SW-1:0] clr_idx;

  logic [1:0] ways_log2;
  logic [3:0] line_bits;
  logic [4:0] capacity_log2;

  row_t mem [MAX_SETS];
  row_t rd_row;
  row_t wr_row;
  logic mem_we;
  logic [SW-1:0] mem_waddr;
  logic mem_re;

  salts_pkg::tally_t hit_tally, hit_tally_next;
  salts_pkg::tally_t miss_tally, miss_tally_next;

  // held item
  logic [1:0]    cmd;
  logic [1:0]    mode;
  logic [AW-1:0] addr;
  logic [AW-1:0] tag;
  logic [SW-1:0] set_idx;
  logic          bad;

  // output register
  logic          out_hit;
  logic          out_vvalid;
  logic [AW-1:0] out_vaddr;
  salts_pkg::tally_t out_hits;
  salts_pkg::tally_t out_misses;
  logic          out_bad;

  // geometry decode on the incoming item
  logic signed [6:0] set_bits;
  logic [4:0] nways;
  logic       bad_in;
  logic [4:0] tag_shift;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] set_mask;
  logic [AW-1:0] set_full;

  always_comb begin
    set_bits  = $signed({2'b00, capacity_log2}) - $signed({3'b000, line_bits})
              - $signed({5'b00000, ways_log2});
    nways     = 5'd1 << ways_log2;
    bad_in    = (set_bits < 0) || (set_bits > 7'(SETS_LOG_FLOOR))
              || (32'(nways) > 32'(MAX_WAYS));
    tag_shift = capacity_log2 - {3'b000, ways_log2};
    in_addr   = s_tdata[2 +: AW];
    set_mask  = (AW'(1) << set_bits[4:0]) - AW'(1);
    set_full  = (in_addr >> line_bits) & set_mask;
  end

  logic accept;
  logic upd_done;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign upd_done = (state == ST_UPD) && (!m_tvalid || m_tready);
  assign mem_re   = accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2     <= salts_pkg::WAYS_LOG2_RST;
      line_bits     <= salts_pkg::LINE_BITS_RST;
      capacity_log2 <= salts_pkg::CAPACITY_LOG2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salts_pkg::REG_WAYS_LOG2:     ways_log2 <= cfg_wdata[1:0];
        salts_pkg::REG_LINE_BITS:     line_bits <= cfg_wdata[3:0];
        salts_pkg::REG_CAPACITY_LOG2: capacity_log2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_row;
    end
    if (mem_re) begin
      rd_row <= mem[SW'(set_full)];
    end
  end

  // lookup, victim choice and row update
  logic [RW-1:0] hit_w, inv_w, lru_w, vic_w, touch_w;
  logic          hit_any, inv_any;
  logic [RW-1:0] best;
  logic [RW-1:0] old_rank;
  logic          do_touch;
  logic          rep;
  row_t          upd_row;

  always_comb begin
    hit_w   = '0;
    hit_any = 1'b0;
    inv_w   = '0;
    inv_any = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (32'(w) < 32'(nways)) begin
        if (rd_row[w][E_VALID] && rd_row[w][E_TAG +: AW] == tag) begin
          hit_any = 1'b1;
          hit_w   = RW'(w);
        end
        if (!rd_row[w][E_VALID]) begin
          inv_any = 1'b1;
          inv_w   = RW'(w);
        end
      end
    end
    lru_w = '0;
    best  = rd_row[0][E_RANK +: RW];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (32'(w) < 32'(nways) && rd_row[w][E_RANK +: RW] < best) begin
        best  = rd_row[w][E_RANK +: RW];
        lru_w = RW'(w);
      end
    end
    vic_w = inv_any ? inv_w : lru_w;
    rep   = (mode == salts_pkg::REPORT_VALID && rd_row[vic_w][E_VALID])
         || (mode == salts_pkg::REPORT_DIRTY && rd_row[vic_w][E_DIRTY]);

    touch_w  = (cmd == salts_pkg::CMD_FILL) ? vic_w : hit_w;
    do_touch = (cmd == salts_pkg::CMD_FILL) || hit_any;
    old_rank = rd_row[touch_w][E_RANK +: RW];

    upd_row = rd_row;
    if (do_touch) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (rd_row[w][E_RANK +: RW] > old_rank) begin
          upd_row[w][E_RANK +: RW] = rd_row[w][E_RANK +: RW] - RW'(1);
        end
      end
      upd_row[touch_w][E_RANK +: RW] = RW'(MAX_WAYS - 1);
    end
    unique case (cmd)
      salts_pkg::CMD_FILL: begin
        upd_row[vic_w][E_VALID]      = 1'b1;
        upd_row[vic_w][E_DIRTY]      = 1'b0;
        upd_row[vic_w][E_TAG +: AW]  = tag;
        upd_row[vic_w][E_ADDR +: AW] = addr;
      end
      salts_pkg::CMD_WRITE: begin
        if (hit_any) upd_row[hit_w][E_DIRTY] = 1'b1;
      end
      salts_pkg::CMD_INVAL: begin
        if (hit_any) upd_row[hit_w][E_VALID] = 1'b0;
      end
      default: ;
    endcase

    hit_tally_next  = hit_tally;
    miss_tally_next = miss_tally;
    if (!bad && cmd != salts_pkg::CMD_FILL) begin
      if (hit_any) begin
        if (hit_tally != '1) hit_tally_next = hit_tally + 1'b1;
      end else if (cmd == salts_pkg::CMD_READ || cmd == salts_pkg::CMD_WRITE) begin
        if (miss_tally != '1) miss_tally_next = miss_tally + 1'b1;
      end
    end
  end

  // memory write select: clearing pass or update
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      wr_row[w] = {RW'(w), {(2 * AW + 2){1'b0}}};
    end
    mem_waddr = clr_idx;
    mem_we    = (state == ST_CLEAR);
    if (state == ST_UPD) begin
      wr_row    = upd_row;
      mem_waddr = set_idx;
      mem_we    = upd_done && !bad;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      hit_tally  <= '0;
      miss_tally <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == MAX_SETS - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (upd_done) begin
        hit_tally  <= hit_tally_next;
        miss_tally <= miss_tally_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= s_tdata[1:0];
      mode    <= s_tdata[35:34];
      addr    <= in_addr;
      tag     <= in_addr >> tag_shift;
      set_idx <= SW'(set_full);
      bad     <= bad_in;
    end
    if (upd_done) begin
      out_hit    <= !bad && cmd != salts_pkg::CMD_FILL && hit_any;
      out_vvalid <= !bad && cmd == salts_pkg::CMD_FILL && rep;
      out_vaddr  <= (!bad && cmd == salts_pkg::CMD_FILL && rep)
                    ? rd_row[vic_w][E_ADDR +: AW] : '0;
      out_hits   <= hit_tally_next;
      out_misses <= miss_tally_next;
      out_bad    <= bad;
    end
  end

  assign m_tdata = {5'b00000, out_bad, out_misses, out_hits,
                    32'(out_vaddr), out_vvalid, out_hit};

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready) else $error("item taken during clear");
  a_hit_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> hit_tally >= $past(hit_tally)) else $error("hit tally fell");
  a_out_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_hit && out_vvalid)) else $error("hit and victim together");
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_bad |-> !out_hit && !out_vvalid) else $error("bad geometry result");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam logic [1:0] REPORT_NONE   = 2'd0;
  localparam logic [1:0] REPORT_UNUSED = 2'd3;
  localparam int NWAYS_MAX = 8;
  localparam int NSETS_MAX = 1024;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [1:0]  cmd;
  } access_t;

  typedef struct packed {
    logic        bad;
    logic [31:0] misses;
    logic [31:0] hits;
    logic [31:0] vaddr;
    logic        vvalid;
    logic        hit;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  // cmd[1:0], address[33:2], report_mode[35:34], zero pad
  logic [salts_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // hit[0], victim_valid[1], victim_address[33:2], hit_count[65:34],
  // miss_count[97:66], bad_geometry[98], zero pad
  logic [salts_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [salts_pkg::CFG_W-1:0] cfg_wdata = '0;

  set_assoc_lru_tag_store_core uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow tag store
  bit          sh_valid [NSETS_MAX*NWAYS_MAX];
  bit          sh_dirty [NSETS_MAX*NWAYS_MAX];
  logic [31:0] sh_tag   [NSETS_MAX*NWAYS_MAX];
  logic [31:0] sh_line  [NSETS_MAX*NWAYS_MAX];
  logic [2:0]  sh_rank  [NSETS_MAX*NWAYS_MAX];
  logic [31:0] sh_hits = '0;
  logic [31:0] sh_misses = '0;
  int geo_ways = 2;
  int geo_line = 6;
  int geo_cap = 15;

  access_t pending_items[$];
  lookup_t expected_lookups[$];
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic [31:0] tag_pool [6];
  logic [31:0] set_pool [3];

  initial begin
    forever #5 clk = ~clk;
  end

  // append an item to the pending queue
  function automatic void queue_item(access_t a);
    pending_items.insert(pending_items.size(), a);
  endfunction

  // make way w of the set at base the most recent
  function automatic void promote(int base, int w);
    logic [2:0] old;
    old = sh_rank[base + w];
    for (int i = 0; i < NWAYS_MAX; i++)
      if (sh_rank[base + i] > old) sh_rank[base + i] = sh_rank[base + i] - 3'd1;
    sh_rank[base + w] = 3'(NWAYS_MAX - 1);
  endfunction

  function automatic lookup_t lookup_step(access_t a);
    lookup_t r;
    int sb, nways, base, victim, found;
    logic [31:0] set_idx, tag;
    logic [2:0] best;
    r = '0;
    nways = 1 << geo_ways;
    sb = geo_cap - geo_line - geo_ways;
    r.bad = (sb < 0) || (sb > 10) || (nways > NWAYS_MAX);
    if (!r.bad) begin
      set_idx = 32'((64'(a.addr) >> geo_line) & ((64'd1 << sb) - 64'd1));
      tag = 32'(64'(a.addr) >> (geo_line + sb));
      base = int'(set_idx) * NWAYS_MAX;
      if (a.cmd == salts_pkg::CMD_FILL) begin
        victim = nways;
        for (int w = 0; w < nways; w++)
          if (!sh_valid[base + w] && victim == nways) victim = w;
        if (victim == nways) begin
          victim = 0;
          best = sh_rank[base];
          for (int w = 1; w < nways; w++)
            if (sh_rank[base + w] < best) begin
              best = sh_rank[base + w];
              victim = w;
            end
        end
        if ((a.mode == salts_pkg::REPORT_VALID && sh_valid[base + victim]) ||
            (a.mode == salts_pkg::REPORT_DIRTY && sh_dirty[base + victim])) begin
          r.vvalid = 1'b1;
          r.vaddr = sh_line[base + victim];
        end
        promote(base, victim);
        sh_dirty[base + victim] = 1'b0;
        sh_tag[base + victim] = tag;
        sh_line[base + victim] = a.addr;
        sh_valid[base + victim] = 1'b1;
      end else begin
        found = nways;
        for (int w = 0; w < nways; w++)
          if (found == nways && sh_valid[base + w] && sh_tag[base + w] == tag) found = w;
        if (found < nways) begin
          r.hit = 1'b1;
          if (sh_hits != '1) sh_hits = sh_hits + 1;
          promote(base, found);
          if (a.cmd == salts_pkg::CMD_WRITE) sh_dirty[base + found] = 1'b1;
          else if (a.cmd == salts_pkg::CMD_INVAL) sh_valid[base + found] = 1'b0;
        end else if (a.cmd == salts_pkg::CMD_READ || a.cmd == salts_pkg::CMD_WRITE) begin
          if (sh_misses != '1) sh_misses = sh_misses + 1;
        end
      end
    end
    r.hits = sh_hits;
    r.misses = sh_misses;
    return r;
  endfunction

  // sender: one item in flight on the bus, refilled from the pending queue
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_lookups.insert(expected_lookups.size(),
                                lookup_step(access_t'(s_tdata[35:0])));
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_tdata <= {4'b0, pending_items.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // receiver: random backpressure and result compare
  always @(posedge clk) begin
    lookup_t want, got;
    m_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) begin
      got = lookup_t'(m_tdata[98:0]);
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: item with nothing expected");
      end else begin
        want = expected_lookups.pop_front();
        check_field("hit", 32'(want.hit), 32'(got.hit));
        check_field("victim_valid", 32'(want.vvalid), 32'(got.vvalid));
        check_field("victim_address", want.vaddr, got.vaddr);
        check_field("hit_count", want.hits, got.hits);
        check_field("miss_count", want.misses, got.misses);
        check_field("bad_geometry", 32'(want.bad), 32'(got.bad));
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_lookups.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(int w, int l, int c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= salts_pkg::REG_WAYS_LOG2;
    cfg_wdata <= salts_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= salts_pkg::REG_LINE_BITS;
    cfg_wdata <= salts_pkg::CFG_W'(l);
    @(posedge clk);
    cfg_index <= salts_pkg::REG_CAPACITY_LOG2;
    cfg_wdata <= salts_pkg::CFG_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    geo_ways = w;
    geo_line = l;
    geo_cap = c;
  endtask

  function automatic logic [31:0] pick_address();
    int sb;
    logic [63:0] low_mask;
    sb = geo_cap - geo_line - geo_ways;
    if (sb < 0 || sb > 10 || $urandom_range(99) < 15) return $urandom;
    low_mask = (64'd1 << (geo_line + sb)) - 64'd1;
    return (tag_pool[$urandom_range(5)] & ~low_mask[31:0])
         | ((set_pool[$urandom_range(2)] & 32'((1 << sb) - 1)) << geo_line)
         | ($urandom & 32'((1 << geo_line) - 1));
  endfunction

  task automatic random_phase(int w, int l, int c, int n, int si, int ri);
    access_t a;
    wait_idle();
    set_geometry(w, l, c);
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    foreach (set_pool[i]) set_pool[i] = $urandom;
    send_idle = si;
    recv_idle = ri;
    for (int i = 0; i < n; i++) begin
      a.cmd = 2'($urandom_range(3));
      a.addr = pick_address();
      a.mode = 2'($urandom_range(3));
      queue_item(a);
    end
  endtask

  function automatic access_t acc(logic [1:0] c, logic [31:0] ad, logic [1:0] m);
    access_t a;
    a.cmd = c;
    a.addr = ad;
    a.mode = m;
    return a;
  endfunction

  initial begin
    for (int i = 0; i < NSETS_MAX*NWAYS_MAX; i++) begin
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_tag[i] = '0;
      sh_line[i] = '0;
      sh_rank[i] = 3'(i % NWAYS_MAX);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle = 22;
    recv_idle = 45;
    // directed: set 1 of the reset geometry, tags 1..9
    for (int t = 1; t <= 5; t++)
      queue_item(acc(salts_pkg::CMD_FILL, (t << 13) | 32'h40, salts_pkg::REPORT_VALID));
    queue_item(acc(salts_pkg::CMD_READ, (2 << 13) | 32'h47, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_WRITE, (3 << 13) | 32'h7f, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_READ, (1 << 13) | 32'h40, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_INVAL, (3 << 13) | 32'h40, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_INVAL, (1 << 13) | 32'h40, REPORT_NONE));
    // dirty invalidated line is the victim here
    queue_item(acc(salts_pkg::CMD_FILL, (6 << 13) | 32'h40, salts_pkg::REPORT_DIRTY));
    queue_item(acc(salts_pkg::CMD_FILL, (7 << 13) | 32'h40, REPORT_UNUSED));
    queue_item(acc(salts_pkg::CMD_FILL, (8 << 13) | 32'h40, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_FILL, (9 << 13) | 32'h40, salts_pkg::REPORT_DIRTY));
    queue_item(acc(salts_pkg::CMD_READ, 32'h0, REPORT_UNUSED));
    queue_item(acc(salts_pkg::CMD_WRITE, 32'hffff_ffff, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_FILL, 32'hffff_ffff, salts_pkg::REPORT_VALID));
    queue_item(acc(salts_pkg::CMD_READ, 32'hffff_ffff, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_WRITE, 32'hffff_ffc0, REPORT_NONE));
    queue_item(acc(salts_pkg::CMD_FILL, 32'h0, salts_pkg::REPORT_DIRTY));
    queue_item(acc(salts_pkg::CMD_INVAL, 32'h0, salts_pkg::REPORT_VALID));
    queue_item(acc(salts_pkg::CMD_FILL, 32'h3f, salts_pkg::REPORT_DIRTY));
    // random phases over several geometries, extremes included
    random_phase(2, 6, 15, 250, 22, 45);
    random_phase(0, 0, 0, 150, 22, 45);
    random_phase(3, 12, 25, 300, 45, 22);
    random_phase(1, 2, 6, 300, 45, 22);
    random_phase(2, 6, 5, 40, 45, 22);
    random_phase(0, 0, 25, 40, 0, 0);
    random_phase(3, 4, 9, 350, 0, 0);
    random_phase(0, 3, 13, 250, 0, 0);
    random_phase(3, 0, 3, 150, 0, 0);
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
